/* rtl/core/lfpr_pkg.sv */
// ----------------------------------------------------------------------------
// lfpr_pkg
// Shared types and constants for the LRU/FIFO page replacement block.
// ----------------------------------------------------------------------------
package lfpr_pkg;

    // Default sizing.
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 16;

    // Fixed widths of the transaction fields.
    localparam int PAGE_FIELD_W  = 16;
    localparam int FRAME_FIELD_W = 4;
    localparam int FAULT_W       = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int LIMIT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    // Update command broadcast to every cell in the resolve cycle.
    typedef struct packed {
        logic en;     // apply an update this cycle
        logic write;  // target cell takes the new page (miss)
        logic all;    // every other valid cell ages, regardless of the limit
    } cell_cmd_t;

endpackage

/* rtl/core/lfpr_cell.sv */
// ----------------------------------------------------------------------------
// lfpr_cell
// One frame of the table: page, valid flag and age rank, with its stage of
// the lookup chain that carries the hit and victim towards the last cell.
// ----------------------------------------------------------------------------
module lfpr_cell
    import lfpr_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int IDX_W  = 4,
    parameter int AGE_W  = 4,
    parameter int PAGE_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PAGE_W-1:0] key,
    input  logic [AGE_W-1:0]  oldest_age,
    input  logic              sample,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  target_idx,
    input  logic [AGE_W-1:0]  age_limit,
    input  logic              hit_in,
    input  logic [IDX_W-1:0]  hit_idx_in,
    input  logic [AGE_W-1:0]  hit_age_in,
    input  logic [IDX_W-1:0]  vic_idx_in,
    input  logic [PAGE_W-1:0] vic_page_in,
    output logic              hit_out,
    output logic [IDX_W-1:0]  hit_idx_out,
    output logic [AGE_W-1:0]  hit_age_out,
    output logic [IDX_W-1:0]  vic_idx_out,
    output logic [PAGE_W-1:0] vic_page_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [PAGE_W-1:0] page_reg;
    logic              valid_reg;
    logic [AGE_W-1:0]  age_reg;
    logic              match_reg;
    logic              victim_reg;
    logic              is_target;

    assign is_target = (target_idx == MY_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            age_reg    <= '0;
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end else begin
            if (sample) begin
                match_reg  <= valid_reg && (page_reg == key);
                victim_reg <= valid_reg && (age_reg == oldest_age);
            end
            if (cmd.en) begin
                if (is_target) begin
                    age_reg <= '0;
                    if (cmd.write) begin
                        valid_reg <= 1'b1;
                    end
                end else if (valid_reg && (cmd.all || (age_reg < age_limit))) begin
                    age_reg <= age_reg + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.en && cmd.write && is_target) begin
            page_reg <= key;
        end
    end

    // Lowest-index match wins, highest-index victim; else inputs pass on.
    always_comb begin
        hit_out      = hit_in || match_reg;
        hit_idx_out  = hit_idx_in;
        hit_age_out  = hit_age_in;
        if (!hit_in && match_reg) begin
            hit_idx_out = MY_IDX;
            hit_age_out = age_reg;
        end
        vic_idx_out  = vic_idx_in;
        vic_page_out = vic_page_in;
        if (victim_reg) begin
            vic_idx_out  = MY_IDX;
            vic_page_out = page_reg;
        end
    end

endmodule

/* rtl/core/lfpr_chain.sv */
// ----------------------------------------------------------------------------
// lfpr_chain
// The row of frame cells, linked so that lookup results ripple from the
// first cell to the last.
// ----------------------------------------------------------------------------
module lfpr_chain
    import lfpr_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int IDX_W      = 4,
    parameter int AGE_W      = 4,
    parameter int PAGE_W     = DEF_PAGE_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PAGE_W-1:0] key,
    input  logic [AGE_W-1:0]  oldest_age,
    input  logic              sample,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  target_idx,
    input  logic [AGE_W-1:0]  age_limit,
    output logic              hit,
    output logic [IDX_W-1:0]  hit_idx,
    output logic [AGE_W-1:0]  hit_age,
    output logic [IDX_W-1:0]  vic_idx,
    output logic [PAGE_W-1:0] vic_page
);

    logic              hit_c      [0:MAX_FRAMES];
    logic [IDX_W-1:0]  hit_idx_c  [0:MAX_FRAMES];
    logic [AGE_W-1:0]  hit_age_c  [0:MAX_FRAMES];
    logic [IDX_W-1:0]  vic_idx_c  [0:MAX_FRAMES];
    logic [PAGE_W-1:0] vic_page_c [0:MAX_FRAMES];

    assign hit_c[0]      = 1'b0;
    assign hit_idx_c[0]  = '0;
    assign hit_age_c[0]  = '0;
    assign vic_idx_c[0]  = '0;
    assign vic_page_c[0] = '0;

    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        lfpr_cell #(
            .INDEX  (i),
            .IDX_W  (IDX_W),
            .AGE_W  (AGE_W),
            .PAGE_W (PAGE_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .key          (key),
            .oldest_age   (oldest_age),
            .sample       (sample),
            .cmd          (cmd),
            .target_idx   (target_idx),
            .age_limit    (age_limit),
            .hit_in       (hit_c[i]),
            .hit_idx_in   (hit_idx_c[i]),
            .hit_age_in   (hit_age_c[i]),
            .vic_idx_in   (vic_idx_c[i]),
            .vic_page_in  (vic_page_c[i]),
            .hit_out      (hit_c[i+1]),
            .hit_idx_out  (hit_idx_c[i+1]),
            .hit_age_out  (hit_age_c[i+1]),
            .vic_idx_out  (vic_idx_c[i+1]),
            .vic_page_out (vic_page_c[i+1])
        );
    end

    assign hit      = hit_c[MAX_FRAMES];
    assign hit_idx  = hit_idx_c[MAX_FRAMES];
    assign hit_age  = hit_age_c[MAX_FRAMES];
    assign vic_idx  = vic_idx_c[MAX_FRAMES];
    assign vic_page = vic_page_c[MAX_FRAMES];

endmodule

/* rtl/core/lru_fifo_page_replacement_top.sv */
// ----------------------------------------------------------------------------
// lru_fifo_page_replacement_top
// Page replacement table with LRU and FIFO policies and a fault counter.
// ----------------------------------------------------------------------------
// Each page reference passes through a lookup and an update state: in ST_LOOK
// every frame cell compares the page with its own entry and flags whether it
// holds the oldest page; in ST_UPD the hit and victim ripple along the row of
// cells, the replacement decision is made and, on a miss or under LRU, the cells
// update their age ranks. ST_UPD waits for the output register to be free, and
// a new reference is accepted as the previous result is registered, or while
// the block is idle. The table needs no clearing pass after reset. Configuration
// must be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lru_fifo_page_replacement_top
    import lfpr_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PAGE_FIELD_W-1:0]  s_page_number,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit,
    output logic [FRAME_FIELD_W-1:0] m_frame_index,
    output logic                     m_evicted_valid,
    output logic [PAGE_FIELD_W-1:0]  m_evicted_page,
    output logic [FAULT_W-1:0]       m_fault_total
);

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AGE_W  = IDX_W;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int PAGE_W = PAGE_BITS;

    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);

    // Configuration.
    logic [LIMIT_W-1:0] frames_in_use_reg;
    logic               policy_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= LIMIT_W'(16);
            policy_mode_reg   <= POLICY_LRU;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAMES_IN_USE: frames_in_use_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_POLICY_MODE:   policy_mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Incoming page, reduced or extended to the internal page width.
    logic [PAGE_W-1:0] page_in;
    if (PAGE_W >= PAGE_FIELD_W) begin : g_page_ext
        assign page_in = PAGE_W'(s_page_number);
    end else begin : g_page_trunc
        assign page_in = s_page_number[PAGE_W-1:0];
    end

    state_t            state_reg, state_next;
    logic [PAGE_W-1:0] key_reg;
    logic [CNT_W-1:0]  filled_reg;
    logic [FAULT_W-1:0] fault_reg;

    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [FRAME_FIELD_W-1:0] out_frame_reg;
    logic               out_ev_valid_reg;
    logic [PAGE_FIELD_W-1:0]  out_ev_page_reg;

    logic              accept;
    logic              advance;
    logic              sample;

    // Chain results.
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [AGE_W-1:0]  hit_age;
    logic [IDX_W-1:0]  vic_idx;
    logic [PAGE_W-1:0] vic_page;

    logic [CNT_W-1:0]  filled_dec;
    logic [AGE_W-1:0]  oldest_age;
    logic [CMP_W-1:0]  filled_cmp;
    logic [CMP_W-1:0]  limit_cmp;
    logic              fill_ok;
    logic              do_fill;
    logic              do_evict;
    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  target_idx;
    logic [FAULT_W-1:0] fault_next;
    logic [FRAME_FIELD_W-1:0] frame_field;
    logic [PAGE_FIELD_W-1:0]  vic_field;

    // The oldest valid frame always carries the rank one below the fill count.
    assign filled_dec = filled_reg - CNT_W'(1);
    assign oldest_age = filled_dec[AGE_W-1:0];

    assign filled_cmp = CMP_W'(filled_reg);
    always_comb begin
        limit_cmp = CMP_W'(frames_in_use_reg);
        if (limit_cmp == '0) begin
            limit_cmp = CMP_W'(1);
        end
        if (limit_cmp > MAX_CMP) begin
            limit_cmp = MAX_CMP;
        end
    end
    assign fill_ok  = (filled_cmp < limit_cmp);
    assign do_fill  = !hit && fill_ok;
    assign do_evict = !hit && !fill_ok;

    always_comb begin
        if (hit) begin
            target_idx = hit_idx;
        end else if (fill_ok) begin
            target_idx = filled_reg[IDX_W-1:0];
        end else begin
            target_idx = vic_idx;
        end
    end

    assign advance   = (state_reg == ST_UPD) && (!out_valid_reg || m_ready);
    assign sample    = (state_reg == ST_LOOK);
    assign s_ready   = (state_reg == ST_IDLE) || advance;
    assign accept    = s_valid && s_ready;

    assign cmd.en    = advance && (!hit || (policy_mode_reg == POLICY_LRU));
    assign cmd.write = !hit;
    assign cmd.all   = !hit;

    assign fault_next = (!hit && (fault_reg != '1)) ? fault_reg + FAULT_W'(1) : fault_reg;

    if (IDX_W >= FRAME_FIELD_W) begin : g_frame_trunc
        assign frame_field = target_idx[FRAME_FIELD_W-1:0];
    end else begin : g_frame_ext
        assign frame_field = FRAME_FIELD_W'(target_idx);
    end

    if (PAGE_W >= PAGE_FIELD_W) begin : g_vic_trunc
        assign vic_field = vic_page[PAGE_FIELD_W-1:0];
    end else begin : g_vic_ext
        assign vic_field = PAGE_FIELD_W'(vic_page);
    end

    lfpr_chain #(
        .MAX_FRAMES (MAX_FRAMES),
        .IDX_W      (IDX_W),
        .AGE_W      (AGE_W),
        .PAGE_W     (PAGE_W)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key        (key_reg),
        .oldest_age (oldest_age),
        .sample     (sample),
        .cmd        (cmd),
        .target_idx (target_idx),
        .age_limit  (hit_age),
        .hit        (hit),
        .hit_idx    (hit_idx),
        .hit_age    (hit_age),
        .vic_idx    (vic_idx),
        .vic_page   (vic_page)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (advance) begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
                fault_reg     <= fault_next;
                if (do_fill) begin
                    filled_reg <= filled_reg + CNT_W'(1);
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg <= page_in;
        end
        if (advance) begin
            out_hit_reg      <= hit;
            out_frame_reg    <= frame_field;
            out_ev_valid_reg <= do_evict;
            out_ev_page_reg  <= do_evict ? vic_field : '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = out_hit_reg;
    assign m_frame_index   = out_frame_reg;
    assign m_evicted_valid = out_ev_valid_reg;
    assign m_evicted_page  = out_ev_page_reg;
    assign m_fault_total   = fault_reg;

endmodule

/* tb/tb_lru_fifo_page_replacement_top.sv */
// ----------------------------------------------------------------------------
// tb_lru_fifo_page_replacement_top
// Self-checking testbench for the LRU/FIFO page replacement table.
// ----------------------------------------------------------------------------
// A short table of directed references covers the page extremes, the first
// fills after reset, a frame limit of zero and one of 31, above the table size, a
// limit lowered below the number of filled frames, hits under both policies
// and replacements under LRU. Random references follow, drawn mostly from a small
// working set per phase so that hits and evictions both occur often. Every
// result is compared with a behavioural model of the replacement table, or for
// typed rows with the row's own values; both channels stall at random apart from one steady stretch.
// ----------------------------------------------------------------------------
module tb_lru_fifo_page_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpr_pkg::*;

    localparam int NUM_FRAMES = DEF_MAX_FRAMES;

    typedef struct packed {
        logic                     hit;
        logic [FRAME_FIELD_W-1:0] frame_index;
        logic                     evicted_valid;
        logic [PAGE_FIELD_W-1:0]  evicted_page;
        logic [FAULT_W-1:0]       fault_total;
    } page_result_t;

    typedef struct packed {
        logic                    load_cfg;
        logic [LIMIT_W-1:0]      limit;
        logic                    mode;
        logic [PAGE_FIELD_W-1:0] page;
        logic                    typed;
        page_result_t            want;
    } directed_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_FRAMES_IN_USE;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [PAGE_FIELD_W-1:0]  s_page_number = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_hit;
    logic [FRAME_FIELD_W-1:0] m_frame_index;
    logic                     m_evicted_valid;
    logic [PAGE_FIELD_W-1:0]  m_evicted_page;
    logic [FAULT_W-1:0]       m_fault_total;

    // Model of the table and its registers.
    logic [LIMIT_W-1:0]      limit_reg = 5'd16;
    logic                    mode_reg = POLICY_LRU;
    logic [PAGE_FIELD_W-1:0] held_page [NUM_FRAMES];
    bit                      resident [NUM_FRAMES];
    bit [3:0]                age_rank [NUM_FRAMES];
    int                      fill_count = 0;
    logic [FAULT_W-1:0]      fault_count = '0;

    page_result_t pending_results [$];
    int           error_count = 0;
    bit           steady = 1'b0;

    directed_row_t directed_plan [24] = '{
        '{1'b0, 5'd0, 1'b0, 16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd1}},
        '{1'b0, 5'd0, 1'b0, 16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0, 32'd2}},
        '{1'b0, 5'd0, 1'b0, 16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0, 32'd2}},
        '{1'b0, 5'd0, 1'b0, 16'h8000, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0, 32'd3}},
        '{1'b0, 5'd0, 1'b0, 16'h7FFF, 1'b1, '{1'b0, 4'd3, 1'b0, 16'h0, 32'd4}},
        // A limit of zero acts as one, and lies below the four frames in use.
        '{1'b1, 5'd0, POLICY_LRU, 16'h0000, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h5555, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h7FFF, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'hAAAA, 1'b0, '0},
        // A limit above the table size saturates, so the remaining frames fill.
        '{1'b1, 5'd31, POLICY_FIFO, 16'h0000, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h8000, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0001, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0002, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0004, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0008, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0010, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0020, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0040, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0080, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0100, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0200, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0400, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h0800, 1'b0, '0},
        '{1'b0, 5'd0, 1'b0, 16'h1000, 1'b0, '0}
    };

    lru_fifo_page_replacement_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_total   (m_fault_total)
    );

    always #10 aclk = ~aclk;

    // Frame 'slot' becomes the most recent; valid frames younger than 'bound' age.
    function automatic void make_newest(input int slot, input int bound);
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (i != slot && resident[i] && age_rank[i] < bound) begin
                age_rank[i] = age_rank[i] + 4'd1;
            end
        end
        age_rank[slot] = 4'd0;
    endfunction

    function automatic page_result_t resolve_reference(input logic [PAGE_FIELD_W-1:0] page);
        page_result_t r;
        int           limit;
        int           slot;
        int           oldest;
        bit           found;
        bit           seen;
        r = '0;
        slot = 0;
        oldest = 0;
        found = 1'b0;
        seen = 1'b0;
        limit = limit_reg;
        if (limit == 0) begin
            limit = 1;
        end
        if (limit > NUM_FRAMES) begin
            limit = NUM_FRAMES;
        end
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (!found && resident[i] && held_page[i] == page) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (mode_reg == POLICY_LRU) begin
                make_newest(slot, age_rank[slot]);
            end
        end else begin
            if (fill_count < limit) begin
                slot = fill_count;
                fill_count++;
                resident[slot] = 1'b1;
            end else begin
                // The oldest frame goes; the lowest index wins a tie.
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (resident[i] && (!seen || age_rank[i] > oldest)) begin
                        oldest = age_rank[i];
                        slot = i;
                        seen = 1'b1;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = held_page[slot];
            end
            held_page[slot] = page;
            make_newest(slot, NUM_FRAMES);
            if (fault_count != '1) begin
                fault_count = fault_count + 1'b1;
            end
        end
        r.frame_index = slot[FRAME_FIELD_W-1:0];
        r.fault_total = fault_count;
        return r;
    endfunction

    // Returns in the time step of acceptance with s_valid still high, so the
    // caller either presents the next page at once or lowers it.
    task automatic send_page(input logic [PAGE_FIELD_W-1:0] page, input bit typed,
                             input page_result_t typed_res);
        page_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        predicted = resolve_reference(page);
        if (typed) begin
            predicted = typed_res;
        end
        pending_results = {pending_results, predicted};
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic mode);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAMES_IN_USE;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_index <= REG_POLICY_MODE;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, mode};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_reg = limit;
        mode_reg = mode;
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge aclk) begin
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with none expected: frame_index %0d",
                       m_frame_index);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, m_hit);
                    error_count++;
                end
                if (m_frame_index !== want.frame_index) begin
                    $error("frame_index: expected %0d, got %0d", want.frame_index,
                           m_frame_index);
                    error_count++;
                end
                if (m_evicted_valid !== want.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                           m_evicted_valid);
                    error_count++;
                end
                if (m_evicted_page !== want.evicted_page) begin
                    $error("evicted_page: expected 0x%04h, got 0x%04h", want.evicted_page,
                           m_evicted_page);
                    error_count++;
                end
                if (m_fault_total !== want.fault_total) begin
                    $error("fault_total: expected %0d, got %0d", want.fault_total,
                           m_fault_total);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [PAGE_FIELD_W-1:0] working_set [24];
        logic [PAGE_FIELD_W-1:0] page;
        logic [LIMIT_W-1:0]      limit;
        logic                    mode;
        int                      set_size;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            held_page[i] = '0;
            resident[i] = 1'b0;
            age_rank[i] = 4'd0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[n]) begin
            if (directed_plan[n].load_cfg) begin
                set_config(directed_plan[n].limit, directed_plan[n].mode);
            end else begin
                send_page(directed_plan[n].page, directed_plan[n].typed,
                          directed_plan[n].want);
            end
        end

        // Each phase uses its own working set; some pages fall outside it.
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    limit = 5'd1;
                    mode = POLICY_LRU;
                end
                1: begin
                    limit = 5'd16;
                    mode = POLICY_FIFO;
                end
                2: begin
                    limit = 5'd0;
                    mode = POLICY_LRU;
                end
                3: begin
                    limit = 5'd31;
                    mode = POLICY_FIFO;
                end
                default: begin
                    limit = LIMIT_W'($urandom_range(0, 31));
                    mode = $urandom_range(0, 1) ? POLICY_LRU : POLICY_FIFO;
                end
            endcase
            set_config(limit, mode);
            steady = (phase == 4 || phase == 5);
            set_size = $urandom_range(2, 24);
            for (int k = 0; k < set_size; k++) begin
                working_set[k] = PAGE_FIELD_W'($urandom);
            end
            repeat (115) begin
                if ($urandom_range(0, 99) < 80) begin
                    page = working_set[$urandom_range(0, set_size - 1)];
                end else begin
                    page = PAGE_FIELD_W'($urandom);
                end
                send_page(page, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_lru_fifo_page_replacement_top: PASS");
        end else begin
            $display("tb_lru_fifo_page_replacement_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_lru_fifo_page_replacement_top: FAIL");
        $finish;
    end

endmodule

/* lru_fifo_page_replacement_top.f */
rtl/core/lfpr_pkg.sv
rtl/core/lfpr_cell.sv
rtl/core/lfpr_chain.sv
rtl/core/lru_fifo_page_replacement_top.sv
tb/tb_lru_fifo_page_replacement_top.sv
